// ===== hdl/frr_pkg.sv =====
// Shared types, constants and CRC helper for the fixed-length frame receiver.
// Used by every module of the block; depends on nothing else.
package frr_pkg;

   localparam int unsigned PayloadBytesDefault = 24;
   localparam int unsigned PayloadBytesMax     = 56;

   // fixed field widths of the result item
   localparam int unsigned ByteW   = 8;
   localparam int unsigned IdW     = 32;
   localparam int unsigned CrcW    = 16;
   localparam int unsigned IndexW  = 6;
   localparam int unsigned RspDataW = 64;

   // CRC-16/XMODEM
   localparam logic [CrcW-1:0] CrcPoly = 16'h1021;
   localparam logic [CrcW-1:0] CrcTop  = 16'h8000;
   localparam logic [CrcW-1:0] CrcInit = 16'h0000;
   localparam int unsigned     CrcBitsPerStep = 4;

   // frame layout offsets relative to the head byte
   localparam int unsigned PosPayload = 5;

   // marker register reset values
   localparam logic [ByteW-1:0] HeadMarkerReset = 8'hA5;
   localparam logic [ByteW-1:0] TailMarkerReset = 8'h5A;

   // configuration register indexes
   typedef enum logic [0:0] {
      CSR_HEAD_MARKER = 1'b0,
      CSR_TAIL_MARKER = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_BAD_HEAD = 2'd1,
      STATUS_BAD_TAIL = 2'd2,
      STATUS_BAD_CRC  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CRC,
      ST_ERROR,
      ST_READ,
      ST_EMIT
   } state_type;

   // control from the sequencer to the CRC unit
   typedef struct packed {
      logic             start;
      logic             clear;
      logic [ByteW-1:0] data;
   } crc_ctrl_type;

   // one MSB-first CRC step on a single message bit
   function automatic logic [CrcW-1:0] crc_bit(input logic [CrcW-1:0] acc,
                                               input logic            din);
      logic [CrcW-1:0] c;
      c = acc ^ {din, {(CrcW-1){1'b0}}};
      if ((c & CrcTop) != '0) begin
         crc_bit = {c[CrcW-2:0], 1'b0} ^ CrcPoly;
      end else begin
         crc_bit = {c[CrcW-2:0], 1'b0};
      end
   endfunction

   // four message bits, MSB first
   function automatic logic [CrcW-1:0] crc_nibble(input logic [CrcW-1:0]           acc,
                                                  input logic [CrcBitsPerStep-1:0] nib);
      logic [CrcW-1:0] c;
      c = acc;
      for (int k = CrcBitsPerStep - 1; k >= 0; k--) begin
         c = crc_bit(c, nib[k]);
      end
      crc_nibble = c;
   endfunction

endpackage

// ===== hdl/frr_crc_unit.sv =====
// Shared CRC-16 unit: folds one byte in four bits a cycle, high nibble first.
// Depends on frr_pkg.
module frr_crc_unit
   import frr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  crc_ctrl_type    ctrl,
   output logic [CrcW-1:0] crc
);

   logic [CrcW-1:0]           acc_ff, acc_in;
   logic [CrcBitsPerStep-1:0] low_ff, low_in;
   logic                      pend_ff, pend_in;

   // high nibble on start, low nibble on the following cycle
   always_comb begin
      acc_in  = acc_ff;
      low_in  = low_ff;
      pend_in = 1'b0;
      if (ctrl.clear) begin
         acc_in = CrcInit;
      end else if (ctrl.start) begin
         acc_in  = crc_nibble(acc_ff, ctrl.data[ByteW-1:CrcBitsPerStep]);
         low_in  = ctrl.data[CrcBitsPerStep-1:0];
         pend_in = 1'b1;
      end else if (pend_ff) begin
         acc_in = crc_nibble(acc_ff, low_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= CrcInit;
         pend_ff <= 1'b0;
      end else begin
         acc_ff  <= acc_in;
         pend_ff <= pend_in;
      end
      low_ff <= low_in;
   end

   assign crc = acc_ff;

endmodule

// ===== hdl/frr_payload_buf.sv =====
// Payload store of one frame: one write port, one registered read port.
// Depends on frr_pkg.
module frr_payload_buf
   import frr_pkg::*;
#(
   parameter int unsigned PAYLOAD_BYTES = PayloadBytesDefault,
   localparam int unsigned AddrW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [ByteW-1:0] wr_data,
   input  logic [AddrW-1:0] rd_addr,
   output logic [ByteW-1:0] rd_data
);

   logic [ByteW-1:0] mem [PAYLOAD_BYTES];
   logic [ByteW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/fixed_frame_receiver_crc16_top.sv =====
// Fixed-length frame receiver, CRC-16/XMODEM check; uses frr_pkg, frr_crc_unit, frr_payload_buf.
// Intake: head, id and payload bytes pass through ST_CRC while the shared CRC unit (four bits a
// cycle) folds in their low nibble; CRC and tail bytes skip it. After the tail byte, an error
// result loads from ST_ERROR once the output is free; ok frames step ST_READ (registered payload
// read), then ST_EMIT (output load) per result, taking no new byte until the last is loaded.
// Synchronous active-high reset: frame state, CRC and output valid cleared, markers reloaded.
module fixed_frame_receiver_crc16_top
   import frr_pkg::*;
#(
   parameter int unsigned PAYLOAD_BYTES = PayloadBytesDefault
) (
   input  logic                clock,
   input  logic                reset,
   // byte requests
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [ByteW-1:0]    req_tdata,   // [7:0] rx_byte
   // results
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RspDataW-1:0] rsp_tdata,   // [31:0] frame_id, [39:32] payload_byte,
                                            // [45:40] payload_index, [61:46] received_crc,
                                            // [63:62] zero
   output logic [1:0]          rsp_tuser,   // [1:0] status
   output logic                rsp_tlast,   // last
   // marker registers
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [0:0]          csr_index,
   input  logic [ByteW-1:0]    csr_data
);

   localparam int unsigned FrameBytes = PAYLOAD_BYTES + 8;
   localparam int unsigned PosW       = $clog2(FrameBytes);
   localparam int unsigned AddrW      = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
   localparam logic [PosW-1:0] PosPay   = PosW'(PosPayload);
   localparam logic [PosW-1:0] PosCrcLo = PosW'(PAYLOAD_BYTES + 5);
   localparam logic [PosW-1:0] PosCrcHi = PosW'(PAYLOAD_BYTES + 6);
   localparam logic [PosW-1:0] PosTail  = PosW'(PAYLOAD_BYTES + 7);
   localparam logic [AddrW-1:0] LastIdx = AddrW'(PAYLOAD_BYTES - 1);

   // marker registers
   logic [ByteW-1:0] head_marker_ff, tail_marker_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_marker_ff <= HeadMarkerReset;
         tail_marker_ff <= TailMarkerReset;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_HEAD_MARKER: head_marker_ff <= csr_data;
            CSR_TAIL_MARKER: tail_marker_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // frame state
   state_type        state_ff, state_in;
   logic [PosW-1:0]  pos_ff, pos_in;
   logic             head_ok_ff, head_ok_in;
   logic [IdW-1:0]   id_ff, id_in;
   logic [CrcW-1:0]  crc_field_ff, crc_field_in;
   status_type       status_ff, status_in;
   logic [AddrW-1:0] rd_idx_ff, rd_idx_in;

   // output register
   logic             out_valid_ff, out_valid_in;
   status_type       out_status_ff, out_status_in;
   logic [IdW-1:0]   out_id_ff, out_id_in;
   logic [ByteW-1:0] out_byte_ff, out_byte_in;
   logic [IndexW-1:0] out_index_ff, out_index_in;
   logic [CrcW-1:0]  out_crc_ff, out_crc_in;
   logic             out_last_ff, out_last_in;

   crc_ctrl_type     crc_ctrl;
   logic [CrcW-1:0]  crc_value;
   logic             buf_wr_en;
   logic [AddrW-1:0] buf_wr_addr;
   logic [ByteW-1:0] buf_rd_data;

   logic             req_fire;
   logic             out_free;
   logic [1:0]       id_lane;

   frr_crc_unit u_crc (
      .clock (clock),
      .reset (reset),
      .ctrl  (crc_ctrl),
      .crc   (crc_value)
   );

   frr_payload_buf #(
      .PAYLOAD_BYTES (PAYLOAD_BYTES)
   ) u_buf (
      .clock   (clock),
      .wr_en   (buf_wr_en),
      .wr_addr (buf_wr_addr),
      .wr_data (req_tdata),
      .rd_addr (rd_idx_ff),
      .rd_data (buf_rd_data)
   );

   assign req_tready  = (state_ff == ST_IDLE);
   assign req_fire    = req_tvalid && req_tready;
   assign out_free    = !out_valid_ff || rsp_tready;
   assign id_lane     = 2'(pos_ff - PosW'(1));
   assign buf_wr_addr = AddrW'(pos_ff - PosPay);

   // sequencer: byte intake, frame checks, result drain
   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      head_ok_in    = head_ok_ff;
      id_in         = id_ff;
      crc_field_in  = crc_field_ff;
      status_in     = status_ff;
      rd_idx_in     = rd_idx_ff;
      crc_ctrl      = '{start: 1'b0, clear: 1'b0, data: req_tdata};
      buf_wr_en     = 1'b0;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_status_in = out_status_ff;
      out_id_in     = out_id_ff;
      out_byte_in   = out_byte_ff;
      out_index_in  = out_index_ff;
      out_crc_in    = out_crc_ff;
      out_last_in   = out_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (pos_ff < PosCrcLo) begin
                  crc_ctrl.start = 1'b1;
                  state_in       = ST_CRC;
               end
               if (pos_ff == '0) begin
                  head_ok_in = (req_tdata == head_marker_ff);
               end else if (pos_ff < PosPay) begin
                  id_in[8*id_lane +: 8] = req_tdata;
               end else if (pos_ff < PosCrcLo) begin
                  buf_wr_en = 1'b1;
               end else if (pos_ff == PosCrcLo) begin
                  crc_field_in[7:0] = req_tdata;
               end else if (pos_ff == PosCrcHi) begin
                  crc_field_in[15:8] = req_tdata;
               end
               if (pos_ff == PosTail) begin
                  // frame complete: head, then tail, then CRC
                  pos_in         = '0;
                  crc_ctrl.clear = 1'b1;
                  rd_idx_in      = '0;
                  priority if (!head_ok_ff) begin
                     status_in = STATUS_BAD_HEAD;
                     state_in  = ST_ERROR;
                  end else if (req_tdata != tail_marker_ff) begin
                     status_in = STATUS_BAD_TAIL;
                     state_in  = ST_ERROR;
                  end else if (crc_value != crc_field_ff) begin
                     status_in = STATUS_BAD_CRC;
                     state_in  = ST_ERROR;
                  end else begin
                     status_in = STATUS_OK;
                     state_in  = ST_READ;
                  end
               end else begin
                  pos_in = pos_ff + PosW'(1);
               end
            end
         end
         ST_CRC: begin
            // CRC unit finishes the low nibble this cycle
            state_in = ST_IDLE;
         end
         ST_ERROR: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_status_in = status_ff;
               out_id_in     = id_ff;
               out_byte_in   = '0;
               out_index_in  = '0;
               out_crc_in    = crc_field_ff;
               out_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_READ: begin
            // buffer read address presented, data registered next cycle
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_status_in = STATUS_OK;
               out_id_in     = id_ff;
               out_byte_in   = buf_rd_data;
               out_index_in  = IndexW'(rd_idx_ff);
               out_crc_in    = crc_field_ff;
               out_last_in   = (rd_idx_ff == LastIdx);
               if (rd_idx_ff == LastIdx) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_idx_in = rd_idx_ff + AddrW'(1);
                  state_in  = ST_READ;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         head_ok_ff   <= 1'b0;
         id_ff        <= '0;
         crc_field_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         head_ok_ff   <= head_ok_in;
         id_ff        <= id_in;
         crc_field_ff <= crc_field_in;
         out_valid_ff <= out_valid_in;
      end
      status_ff     <= status_in;
      rd_idx_ff     <= rd_idx_in;
      out_status_ff <= out_status_in;
      out_id_ff     <= out_id_in;
      out_byte_ff   <= out_byte_in;
      out_index_ff  <= out_index_in;
      out_crc_ff    <= out_crc_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_crc_ff, out_index_ff, out_byte_ff, out_id_ff};
   assign rsp_tuser  = out_status_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== bench/frr_tb_pkg.sv =====
// Bench-side helpers for the fixed-length frame receiver: CRC-16/XMODEM byte update.
// Shared by the frame checker and the stimulus top; depends on nothing else.
package frr_tb_pkg;

   localparam logic [15:0] XmodemPoly = 16'h1021;
   localparam int unsigned FrameOverhead = 8;

   // CRC-16/XMODEM over one byte, MSB first, no reflection
   function automatic logic [15:0] xmodem_crc_byte(input logic [15:0] acc,
                                                   input logic [7:0]  b);
      logic [15:0] c;
      c = acc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ XmodemPoly;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== bench/frr_frame_checker.sv =====
// Frame checker: watches the byte, result and marker channels of the frame receiver,
// predicts the result stream per frame and compares it field by field.
// Depends on frr_pkg (block types) and frr_tb_pkg (CRC helper).
module frr_frame_checker
   import frr_pkg::*;
   import frr_tb_pkg::*;
#(
   parameter int unsigned PAYLOAD_BYTES = PayloadBytesDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tready,
   input  logic [ByteW-1:0]    req_tdata,
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic [RspDataW-1:0] rsp_tdata,
   input  logic [1:0]          rsp_tuser,
   input  logic                rsp_tlast,
   input  logic                csr_valid,
   input  logic                csr_ready,
   input  logic [0:0]          csr_index,
   input  logic [ByteW-1:0]    csr_data,
   output int unsigned         fail_count,
   output int unsigned         outstanding,
   output int unsigned         results_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned PosCrcLo = PosPayload + PAYLOAD_BYTES;
   localparam int unsigned PosCrcHi = PosCrcLo + 1;
   localparam int unsigned PosTail  = PosCrcLo + 2;

   typedef struct packed {
      status_type       status;
      logic [IdW-1:0]   frame_id;
      logic [ByteW-1:0] pbyte;
      logic [IndexW-1:0] pindex;
      logic [CrcW-1:0]  rx_crc;
      logic             is_last;
   } frame_result_type;

   frame_result_type frame_results_q[$];

   // predicted receiver state
   logic [6:0]       frame_pos;
   logic [CrcW-1:0]  crc_run;
   logic             head_ok;
   logic [IdW-1:0]   frame_id_reg;
   logic [CrcW-1:0]  crc_rx;
   logic [ByteW-1:0] payload_mem [PAYLOAD_BYTES];
   logic [ByteW-1:0] head_mark;
   logic [ByteW-1:0] tail_mark;

   int unsigned errors  = 0;
   int unsigned checked = 0;

   task automatic push_result(input status_type st, input logic [ByteW-1:0] pb,
                              input logic [IndexW-1:0] idx, input logic lastf);
      frame_result_type r;
      r.status   = st;
      r.frame_id = frame_id_reg;
      r.pbyte    = pb;
      r.pindex   = idx;
      r.rx_crc   = crc_rx;
      r.is_last  = lastf;
      frame_results_q.push_back(r);
   endtask

   // advance the frame state by one received byte; tail byte yields the results
   task automatic absorb_byte(input logic [ByteW-1:0] b);
      int unsigned     pos;
      logic [CrcW-1:0] calc;
      pos = frame_pos;
      if (pos < PosCrcLo) begin
         crc_run = xmodem_crc_byte(crc_run, b);
      end
      if (pos == 0) begin
         head_ok = (b == head_mark);
      end else if (pos < PosPayload) begin
         frame_id_reg[8*(pos-1) +: 8] = b;
      end else if (pos < PosCrcLo) begin
         payload_mem[pos-PosPayload] = b;
      end else if (pos == PosCrcLo) begin
         crc_rx[7:0] = b;
      end else if (pos == PosCrcHi) begin
         crc_rx[15:8] = b;
      end
      if (pos < PosTail) begin
         frame_pos = 7'(pos + 1);
      end else begin
         calc      = crc_run;
         frame_pos = '0;
         crc_run   = CrcInit;
         // head check wins over tail, tail over CRC
         if (!head_ok) begin
            push_result(STATUS_BAD_HEAD, '0, '0, 1'b1);
         end else if (b != tail_mark) begin
            push_result(STATUS_BAD_TAIL, '0, '0, 1'b1);
         end else if (calc != crc_rx) begin
            push_result(STATUS_BAD_CRC, '0, '0, 1'b1);
         end else begin
            for (int n = 0; n < PAYLOAD_BYTES; n++) begin
               push_result(STATUS_OK, payload_mem[n], IndexW'(n), n == PAYLOAD_BYTES - 1);
            end
         end
      end
   endtask

   // compare one accepted result with the oldest prediction
   task automatic check_result();
      frame_result_type want;
      logic             bad;
      checked++;
      if (frame_results_q.size() == 0) begin
         errors++;
         if (errors <= 10) begin
            $display("[%0t] unexpected result: status %0d id %h data %h last %b",
                     $realtime, rsp_tuser, rsp_tdata[31:0], rsp_tdata, rsp_tlast);
         end
      end else begin
         want = frame_results_q.pop_front();
         bad  = (rsp_tuser != want.status) || (rsp_tdata[31:0] != want.frame_id) ||
                (rsp_tdata[39:32] != want.pbyte) || (rsp_tdata[45:40] != want.pindex) ||
                (rsp_tdata[61:46] != want.rx_crc) || (rsp_tdata[63:62] != 2'b00) ||
                (rsp_tlast != want.is_last);
         if (bad) begin
            errors++;
            if (errors <= 10) begin
               $display("[%0t] mismatch: expected status %0d id %h byte %h idx %0d crc %h last %b",
                        $realtime, want.status, want.frame_id, want.pbyte, want.pindex,
                        want.rx_crc, want.is_last);
               $display("      got status %0d id %h byte %h idx %0d crc %h last %b pad %b",
                        rsp_tuser, rsp_tdata[31:0], rsp_tdata[39:32], rsp_tdata[45:40],
                        rsp_tdata[61:46], rsp_tlast, rsp_tdata[63:62]);
            end
         end
      end
   endtask

   // sample all channels at the clock edge
   always @(posedge clock) begin
      if (reset) begin
         frame_pos    = '0;
         crc_run      = CrcInit;
         head_ok      = 1'b0;
         frame_id_reg = '0;
         crc_rx       = '0;
         head_mark    = HeadMarkerReset;
         tail_mark    = TailMarkerReset;
         frame_results_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_HEAD_MARKER) begin
               head_mark = csr_data;
            end else begin
               tail_mark = csr_data;
            end
         end
         if (req_tvalid && req_tready) begin
            absorb_byte(req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            check_result();
         end
      end
      fail_count      <= errors;
      outstanding     <= frame_results_q.size();
      results_checked <= checked;
   end

endmodule

// ===== bench/tb_top.sv =====
// Stimulus top for the fixed-length frame receiver: builds frames of every kind, drives
// bytes with random gaps and marker writes, applies result back-pressure, and reports the verdict.
// Depends on frr_pkg, frr_tb_pkg, frr_frame_checker and the receiver RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import frr_pkg::*;
   import frr_tb_pkg::*;

   localparam int unsigned PAYLOAD_BYTES = PayloadBytesDefault;
   localparam int unsigned FrameLen      = PAYLOAD_BYTES + FrameOverhead;
   localparam int unsigned PosCrcLo      = PosPayload + PAYLOAD_BYTES;
   localparam int unsigned SettleCycles  = 16;

   typedef enum int {
      FRAME_GOOD,
      FRAME_BAD_HEAD,
      FRAME_BAD_TAIL,
      FRAME_BAD_CRC,
      FRAME_ALL_BAD,
      FRAME_TAIL_CRC_BAD,
      FRAME_NOISE
   } frame_kind_type;

   typedef enum int {
      FILL_RANDOM,
      FILL_ALTERNATE,
      FILL_ZERO
   } fill_mode_type;

   logic                clock;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ByteW-1:0]    req_tdata  = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspDataW-1:0] rsp_tdata;
   logic [1:0]          rsp_tuser;
   logic                rsp_tlast;
   logic                csr_valid  = 1'b0;
   logic                csr_ready;
   logic [0:0]          csr_index  = CSR_HEAD_MARKER;
   logic [ByteW-1:0]    csr_data   = '0;

   int unsigned fail_count;
   int unsigned outstanding;
   int unsigned results_checked;

   logic [ByteW-1:0] frame_buf [FrameLen];
   logic [ByteW-1:0] head_cur = HeadMarkerReset;
   logic [ByteW-1:0] tail_cur = TailMarkerReset;
   bit               calm     = 1'b0;
   int unsigned      frames_sent   = 0;
   int unsigned      random_frames = 0;
   int unsigned      settings_used = 1;

   fixed_frame_receiver_crc16_top #(
      .PAYLOAD_BYTES(PAYLOAD_BYTES)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   frr_frame_checker #(
      .PAYLOAD_BYTES(PAYLOAD_BYTES)
   ) chk (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .fail_count      (fail_count),
      .outstanding     (outstanding),
      .results_checked (results_checked)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // result back-pressure, none during a calm phase
   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= 38);
   end

   // hard stop
   initial begin
      #2_000_000;
      $display("[fixed_frame_receiver_crc16_top] ERROR");
      $finish;
   end

   // assemble one frame in frame_buf under the current head marker
   task automatic build_frame(input frame_kind_type kind, input logic [IdW-1:0] id,
                              input fill_mode_type fill, input logic [ByteW-1:0] tail_byte);
      logic [CrcW-1:0] crc;
      frame_buf[0] = head_cur;
      if (kind == FRAME_BAD_HEAD || kind == FRAME_ALL_BAD) begin
         frame_buf[0] = head_cur ^ 8'($urandom_range(1, 255));
      end
      for (int i = 0; i < 4; i++) begin
         frame_buf[1+i] = id[8*i +: 8];
      end
      for (int i = 0; i < PAYLOAD_BYTES; i++) begin
         unique case (fill)
            FILL_ALTERNATE: frame_buf[PosPayload+i] = i[0] ? 8'hFF : 8'h00;
            FILL_ZERO:      frame_buf[PosPayload+i] = 8'h00;
            default:        frame_buf[PosPayload+i] = 8'($urandom);
         endcase
      end
      crc = CrcInit;
      for (int i = 0; i < PosCrcLo; i++) begin
         crc = xmodem_crc_byte(crc, frame_buf[i]);
      end
      if (kind == FRAME_BAD_CRC || kind == FRAME_ALL_BAD || kind == FRAME_TAIL_CRC_BAD) begin
         crc ^= 16'h0001 << $urandom_range(15);
      end
      frame_buf[PosCrcLo]   = crc[7:0];
      frame_buf[PosCrcLo+1] = crc[15:8];
      frame_buf[FrameLen-1] = tail_byte;
      if (kind == FRAME_BAD_TAIL || kind == FRAME_ALL_BAD || kind == FRAME_TAIL_CRC_BAD) begin
         frame_buf[FrameLen-1] = tail_byte ^ 8'($urandom_range(1, 255));
      end
      // noise: a frame-sized run of arbitrary bytes
      if (kind == FRAME_NOISE) begin
         for (int i = 0; i < FrameLen; i++) begin
            frame_buf[i] = 8'($urandom);
         end
      end
   endtask

   // one byte request, with random idle cycles ahead of it
   task automatic send_byte(input logic [ByteW-1:0] b);
      while (!calm && $urandom_range(99) < 38) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_bytes(input int unsigned from, input int unsigned upto);
      for (int unsigned i = from; i < upto; i++) begin
         send_byte(frame_buf[i]);
      end
   endtask

   task automatic send_frame(input frame_kind_type kind, input logic [IdW-1:0] id,
                             input fill_mode_type fill);
      build_frame(kind, id, fill, tail_cur);
      send_bytes(0, FrameLen);
      frames_sent++;
   endtask

   // wait for all predicted results, then let the block settle
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [ByteW-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
      if (idx == CSR_HEAD_MARKER) begin
         head_cur = val;
      end else begin
         tail_cur = val;
      end
   endtask

   task automatic set_markers(input logic [ByteW-1:0] h, input logic [ByteW-1:0] t);
      write_csr(CSR_HEAD_MARKER, h);
      write_csr(CSR_TAIL_MARKER, t);
      settings_used++;
   endtask

   function automatic frame_kind_type pick_kind();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 60) return FRAME_GOOD;
      if (r < 70) return FRAME_BAD_HEAD;
      if (r < 80) return FRAME_BAD_TAIL;
      if (r < 90) return FRAME_BAD_CRC;
      return FRAME_NOISE;
   endfunction

   // main sequence
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed frames under the reset markers
      send_frame(FRAME_GOOD, 32'hFFFF_FFFF, FILL_ALTERNATE);
      send_frame(FRAME_GOOD, 32'h0000_0000, FILL_ZERO);
      send_frame(FRAME_BAD_HEAD, $urandom, FILL_RANDOM);
      send_frame(FRAME_BAD_TAIL, $urandom, FILL_RANDOM);
      send_frame(FRAME_BAD_CRC, $urandom, FILL_RANDOM);
      send_frame(FRAME_ALL_BAD, $urandom, FILL_RANDOM);
      send_frame(FRAME_TAIL_CRC_BAD, $urandom, FILL_RANDOM);
      wait_idle();

      // markers change mid-frame: head judged by the old marker, tail by the new one
      build_frame(FRAME_GOOD, $urandom, FILL_RANDOM, 8'h3C);
      send_bytes(0, 12);
      wait_idle();
      set_markers(8'h00, 8'h3C);
      send_bytes(12, FrameLen);
      frames_sent++;
      wait_idle();

      // random phases, extremes of the markers among them
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       set_markers(8'h00, 8'hFF);
            1:       set_markers(8'hFF, 8'h00);
            3:       set_markers(HeadMarkerReset, TailMarkerReset);
            default: set_markers(8'($urandom), 8'($urandom));
         endcase
         calm = (phase == 2);
         send_frame(pick_kind(), $urandom, FILL_RANDOM);
         random_frames++;
         wait_idle();
         calm = 1'b0;
      end

      $display("Run covered %0d frames (%0d random) over %0d marker settings,",
               frames_sent, random_frames, settings_used);
      $display("with %0d results compared against the predicted stream.", results_checked);
      if (fail_count == 0 && outstanding == 0) begin
         $display("[fixed_frame_receiver_crc16_top] OK");
      end else begin
         $display("[fixed_frame_receiver_crc16_top] ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/frr_pkg.sv
hdl/frr_crc_unit.sv
hdl/frr_payload_buf.sv
hdl/fixed_frame_receiver_crc16_top.sv
bench/frr_tb_pkg.sv
bench/frr_frame_checker.sv
bench/tb_top.sv
